// ===== rtl/length_prefixed_frame_parser_macros.svh =====
`ifndef LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define LPFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfp check failed");

// next-cycle implication, off during reset
`define LPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfp check failed");

`endif

// ===== rtl/lpfp_pkg.sv =====
`default_nettype none

package lpfp_pkg;

  localparam int HdrBytes  = 4;
  localparam int HdrCntW   = 3;
  localparam int HdrShiftW = 24;
  localparam int LenW      = 32;
  localparam int ByteW     = 8;
  localparam int DataW     = 32;
  localparam int PaddrW    = 2;

  localparam logic [PaddrW-1:0] RegMaxBodyLenAddr = PaddrW'(0);

  typedef enum logic [1:0] {
    StNeedMore = 2'd0,
    StReady    = 2'd1,
    StTooLarge = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_frame_parser.sv =====
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// input    | in_valid_i / in_ready_o     | data_byte_i
// result   | out_valid_o / out_ready_i   | status_o body_valid_o body_byte_o
//          |                             | body_last_o declared_length_o at_boundary_o
// config   | psel/penable/pwrite, pready | paddr pwdata prdata
//
// one byte transfer per cycle while no result stalls; each result is registered and shows
// in the cycle after its transfer; each state update is a decrement, shift or length compare
// the result register frees in the cycle it is taken, so in_ready_o follows out_ready_i
// reset clears the header, body and skip state and sets max_body_length to zero
// a stalled result holds and blocks further input transfers until taken
`default_nettype none

module length_prefixed_frame_parser
  import lpfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ByteW-1:0]  data_byte_i,

  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic                   body_valid_o,
  output logic [ByteW-1:0]       body_byte_o,
  output logic                   body_last_o,
  output logic [LenW-1:0]        declared_length_o,
  output logic                   at_boundary_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  logic [LenW-1:0]      max_len_q;
  logic [HdrCntW-1:0]   hdr_cnt_q, hdr_cnt_d;
  logic [HdrShiftW-1:0] hdr_shift_q, hdr_shift_d;
  logic                 in_body_q, in_body_d;
  logic [LenW-1:0]      frame_len_q, frame_len_d;
  logic [LenW-1:0]      body_rem_q, body_rem_d;
  logic [LenW-1:0]      skip_q, skip_d;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic                 body_valid_q, body_valid_d;
  logic [ByteW-1:0]     body_byte_q, body_byte_d;
  logic                 body_last_q, body_last_d;
  logic [LenW-1:0]      decl_q, decl_d;
  logic                 boundary_q, boundary_d;

  logic                 in_xfer;
  logic                 hdr_last;
  logic [LenW-1:0]      hdr_len;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == RegMaxBodyLenAddr) ? max_len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '0;
    end else if (psel && penable && pwrite && (paddr == RegMaxBodyLenAddr)) begin
      max_len_q <= pwdata;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign hdr_last = ({1'b0, hdr_cnt_q} + (HdrCntW+1)'(1)) >= (HdrCntW+1)'(HdrBytes);
  assign hdr_len  = {hdr_shift_q, data_byte_i};

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    hdr_shift_d  = hdr_shift_q;
    in_body_d    = in_body_q;
    frame_len_d  = frame_len_q;
    body_rem_d   = body_rem_q;
    skip_d       = skip_q;
    status_d     = StNeedMore;
    body_valid_d = 1'b0;
    body_byte_d  = '0;
    body_last_d  = 1'b0;
    decl_d       = '0;

    if (skip_q != '0) begin
      skip_d = skip_q - LenW'(1);
    end else if (in_body_q) begin
      body_valid_d = 1'b1;
      body_byte_d  = data_byte_i;
      if (body_rem_q <= LenW'(1)) begin
        body_rem_d  = '0;
        in_body_d   = 1'b0;
        body_last_d = 1'b1;
        status_d    = StReady;
        decl_d      = frame_len_q;
      end else begin
        body_rem_d = body_rem_q - LenW'(1);
      end
    end else if (!hdr_last) begin
      hdr_shift_d = {hdr_shift_q[HdrShiftW-ByteW-1:0], data_byte_i};
      hdr_cnt_d   = hdr_cnt_q + HdrCntW'(1);
    end else begin
      hdr_cnt_d   = '0;
      hdr_shift_d = '0;
      decl_d      = hdr_len;
      if (hdr_len > max_len_q) begin
        skip_d   = hdr_len;
        status_d = StTooLarge;
      end else if (hdr_len == '0) begin
        status_d = StReady;
      end else begin
        in_body_d   = 1'b1;
        frame_len_d = hdr_len;
        body_rem_d  = hdr_len;
      end
    end

    boundary_d = (hdr_cnt_d == '0) && !in_body_d && (skip_d == '0);
  end

  // parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      hdr_shift_q <= '0;
      in_body_q   <= 1'b0;
      frame_len_q <= '0;
      body_rem_q  <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        hdr_cnt_q   <= hdr_cnt_d;
        hdr_shift_q <= hdr_shift_d;
        in_body_q   <= in_body_d;
        frame_len_q <= frame_len_d;
        body_rem_q  <= body_rem_d;
        skip_q      <= skip_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q     <= status_d;
      body_valid_q <= body_valid_d;
      body_byte_q  <= body_byte_d;
      body_last_q  <= body_last_d;
      decl_q       <= decl_d;
      boundary_q   <= boundary_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign body_valid_o      = body_valid_q;
  assign body_byte_o       = body_byte_q;
  assign body_last_o       = body_last_q;
  assign declared_length_o = decl_q;
  assign at_boundary_o     = boundary_q;

endmodule

`default_nettype wire

// ===== rtl/lpfp_checker.sv =====
`default_nettype none
`include "length_prefixed_frame_parser_macros.svh"

module lpfp_checker
  import lpfp_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       status_o,
  input wire logic             body_valid_o,
  input wire logic [ByteW-1:0] body_byte_o,
  input wire logic             body_last_o,
  input wire logic [LenW-1:0]  declared_length_o,
  input wire logic             at_boundary_o
);

  // a stalled result holds
  `LPFP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(body_byte_o) && $stable(declared_length_o) && $stable(status_o))

  // no body byte means a zero byte and no last mark
  `LPFP_ASSERT_IMPLY(a_idle_byte, clk_i, rst_ni, out_valid_o && !body_valid_o, body_byte_o == '0 && !body_last_o)

  // the last body byte closes the frame
  `LPFP_ASSERT_IMPLY(a_last_ready, clk_i, rst_ni, out_valid_o && body_last_o, body_valid_o && status_o == StReady && at_boundary_o)

  // an oversized frame always starts a skip
  `LPFP_ASSERT_IMPLY(a_too_large, clk_i, rst_ni, out_valid_o && status_o == StTooLarge, declared_length_o != '0 && !at_boundary_o && !body_valid_o)

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import lpfp_pkg::*;

  localparam int RandItems  = 925;
  localparam int StallLimit = 2000;

  typedef struct packed {
    status_e         status;
    logic            body_valid;
    logic [ByteW-1:0] body_byte;
    logic            body_last;
    logic [LenW-1:0] decl_len;
    logic            at_boundary;
  } frame_result_t;

  typedef struct packed {
    logic          preset;
    frame_result_t res;
  } item_tag_t;

  typedef struct packed {
    logic             set_max;
    logic [LenW-1:0]  max_val;
    logic [ByteW-1:0] data;
    item_tag_t        tag;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ByteW-1:0]  data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic              body_valid_o;
  logic [ByteW-1:0]  body_byte_o;
  logic              body_last_o;
  logic [LenW-1:0]   declared_length_o;
  logic              at_boundary_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  length_prefixed_frame_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .body_valid_o      (body_valid_o),
    .body_byte_o       (body_byte_o),
    .body_last_o       (body_last_o),
    .declared_length_o (declared_length_o),
    .at_boundary_o     (at_boundary_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // parser state mirror
  logic [HdrCntW-1:0]   hdr_cnt;
  logic [HdrShiftW-1:0] hdr_acc;
  logic                 in_frame;
  logic [LenW-1:0]      frame_len;
  logic [LenW-1:0]      body_left;
  logic [LenW-1:0]      skip_left;
  logic [LenW-1:0]      max_len;

  frame_result_t pending_results[$];
  item_tag_t     preset_q[$];
  logic [ByteW-1:0] frame_stream[$];
  dir_row_t      dir_rows[$];

  bit in_fire;
  bit out_fire;
  bit send_calm;
  bit recv_calm;
  int err_count;
  int idle_cycles;

  function automatic frame_result_t parse_byte(logic [ByteW-1:0] b);
    frame_result_t   r;
    logic [LenW-1:0] len;
    r.status      = StNeedMore;
    r.body_valid  = 1'b0;
    r.body_byte   = '0;
    r.body_last   = 1'b0;
    r.decl_len    = '0;
    r.at_boundary = 1'b0;
    if (skip_left != 0) begin
      skip_left = skip_left - 1;
    end else if (in_frame) begin
      r.body_valid = 1'b1;
      r.body_byte  = b;
      if (body_left <= 1) begin
        body_left   = '0;
        in_frame    = 1'b0;
        r.body_last = 1'b1;
        r.status    = StReady;
        r.decl_len  = frame_len;
      end else begin
        body_left = body_left - 1;
      end
    end else if (hdr_cnt + 1 < HdrBytes) begin
      hdr_acc = {hdr_acc[HdrShiftW-ByteW-1:0], b};
      hdr_cnt = hdr_cnt + 1'b1;
    end else begin
      len        = LenW'({hdr_acc, b});
      hdr_cnt    = '0;
      hdr_acc    = '0;
      r.decl_len = len;
      if (len > max_len) begin
        skip_left = len;
        r.status  = StTooLarge;
      end else if (len == 0) begin
        r.status = StReady;
      end else begin
        in_frame  = 1'b1;
        frame_len = len;
        body_left = len;
      end
    end
    r.at_boundary = (hdr_cnt == 0) && !in_frame && (skip_left == 0);
    return r;
  endfunction

  function automatic frame_result_t mk_res(status_e st, logic bv, logic [ByteW-1:0] bb,
                                           logic bl, logic [LenW-1:0] dl, logic ab);
    frame_result_t r;
    r.status      = st;
    r.body_valid  = bv;
    r.body_byte   = bb;
    r.body_last   = bl;
    r.decl_len    = dl;
    r.at_boundary = ab;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic set_max, logic [LenW-1:0] max_val,
                                      logic [ByteW-1:0] data, logic preset, frame_result_t res);
    dir_row_t row;
    row.set_max    = set_max;
    row.max_val    = max_val;
    row.data       = data;
    row.tag.preset = preset;
    row.tag.res    = res;
    return row;
  endfunction

  function automatic void check_field(string name, logic [LenW-1:0] exp_v, logic [LenW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // handshakes and outputs are sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    item_tag_t     tag;
    frame_result_t pred;
    frame_result_t exp_r;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (in_fire) begin
      pred = parse_byte(data_byte_i);
      tag  = preset_q.pop_front();
      pending_results.push_back(tag.preset ? tag.res : pred);
    end
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", LenW'(exp_r.status), LenW'(status_o));
        check_field("body_valid", LenW'(exp_r.body_valid), LenW'(body_valid_o));
        check_field("body_byte", LenW'(exp_r.body_byte), LenW'(body_byte_o));
        check_field("body_last", LenW'(exp_r.body_last), LenW'(body_last_o));
        check_field("declared_length", exp_r.decl_len, declared_length_o);
        check_field("at_boundary", LenW'(exp_r.at_boundary), LenW'(at_boundary_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("length_prefixed_frame_parser verification failed");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!out_fire);
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic put_byte(logic [ByteW-1:0] b, item_tag_t tag);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    preset_q.push_back(tag);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_fire);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_max(logic [LenW-1:0] val);
    logic [DataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegMaxBodyLenAddr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    max_len = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      $error("max_body_length readback: expected %0h, got %0h", val, rd);
      err_count++;
    end
  endtask

  function automatic logic [LenW-1:0] pick_max();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 8);
      3:       return $urandom_range(9, 40);
      4:       return $urandom | 32'h8000_0000;
      default: return $urandom_range(41, 300);
    endcase
  endfunction

  // whole frames of random content; some lengths are drawn from the current limit
  function automatic void add_frame();
    int unsigned     sel;
    logic [LenW-1:0] len;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      len = '0;
    end else if (sel < 5 && max_len < 300) begin
      len = max_len + $urandom_range(1, 20);
    end else if (sel < 7 && max_len <= 300 && max_len != 0) begin
      len = max_len;
    end else if (sel == 7) begin
      len = $urandom_range(41, 300);
    end else begin
      len = $urandom_range(1, 24);
    end
    for (int i = HdrBytes - 1; i >= 0; i--) frame_stream.push_back(len[i*ByteW +: ByteW]);
    for (int i = 0; i < len; i++) frame_stream.push_back(ByteW'($urandom));
  endfunction

  initial begin
    frame_result_t hdr;
    frame_result_t no_preset;
    int unsigned   sent;
    int unsigned   chunk;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hdr_cnt     = '0;
    hdr_acc     = '0;
    in_frame    = 1'b0;
    frame_len   = '0;
    body_left   = '0;
    skip_left   = '0;
    max_len     = '0;
    err_count   = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    hdr       = mk_res(StNeedMore, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0);
    no_preset = hdr;
    // zero length with the reset limit
    repeat (3) dir_rows.push_back(mk_row(1'b0, '0, 8'h00, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h00, 1'b1,
                              mk_res(StReady, 1'b0, 8'h00, 1'b0, 32'd0, 1'b1)));
    // oversized frame and its skipped bytes
    repeat (3) dir_rows.push_back(mk_row(1'b0, '0, 8'h00, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h02, 1'b1,
                              mk_res(StTooLarge, 1'b0, 8'h00, 1'b0, 32'd2, 1'b0)));
    dir_rows.push_back(mk_row(1'b0, '0, 8'hFF, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h5A, 1'b1,
                              mk_res(StNeedMore, 1'b0, 8'h00, 1'b0, 32'd0, 1'b1)));
    // body exactly at the limit
    dir_rows.push_back(mk_row(1'b1, 32'd3, 8'h00, 1'b1, hdr));
    repeat (2) dir_rows.push_back(mk_row(1'b0, '0, 8'h00, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h03, 1'b1,
                              mk_res(StNeedMore, 1'b0, 8'h00, 1'b0, 32'd3, 1'b0)));
    dir_rows.push_back(mk_row(1'b0, '0, 8'hAA, 1'b1,
                              mk_res(StNeedMore, 1'b1, 8'hAA, 1'b0, 32'd0, 1'b0)));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h55, 1'b1,
                              mk_res(StNeedMore, 1'b1, 8'h55, 1'b0, 32'd0, 1'b0)));
    dir_rows.push_back(mk_row(1'b0, '0, 8'hFF, 1'b1,
                              mk_res(StReady, 1'b1, 8'hFF, 1'b1, 32'd3, 1'b1)));
    // limit lowered while a header is half gathered
    repeat (2) dir_rows.push_back(mk_row(1'b0, '0, 8'h00, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b1, 32'd1, 8'h00, 1'b1, hdr));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h02, 1'b1,
                              mk_res(StTooLarge, 1'b0, 8'h00, 1'b0, 32'd2, 1'b0)));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h80, 1'b0, no_preset));
    dir_rows.push_back(mk_row(1'b0, '0, 8'h7F, 1'b0, no_preset));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_max) begin
        drain();
        write_max(dir_rows[i].max_val);
      end
      put_byte(dir_rows[i].data, dir_rows[i].tag);
    end

    sent = 0;
    while (sent < RandItems || frame_stream.size() != 0) begin
      drain();
      write_max(pick_max());
      chunk = $urandom_range(30, 150);
      for (int k = 0; k < chunk; k++) begin
        if (frame_stream.size() == 0) begin
          if (sent >= RandItems) break;
          add_frame();
        end
        put_byte(frame_stream.pop_front(), '{1'b0, no_preset});
        sent++;
      end
    end

    // largest declared length, left skipping to the end of the run
    drain();
    write_max(32'hFFFF_FFFE);
    repeat (HdrBytes) put_byte(8'hFF, '{1'b0, no_preset});
    repeat (3) put_byte(ByteW'($urandom), '{1'b0, no_preset});
    drain();
    repeat (8) @(posedge clk_i);

    if (err_count == 0) begin
      $display("length_prefixed_frame_parser verification clean");
    end else begin
      $display("length_prefixed_frame_parser verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/lpfp_pkg.sv
rtl/length_prefixed_frame_parser.sv
rtl/lpfp_checker.sv
bench/tb.sv
